// ----- rtl/core/s3964_pkg.sv -----
// shared types and constants for the 3964r receiver core
// no dependencies; imported by every module of the core

package s3964_pkg;

    // control characters of the link
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;

    // reply codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_DLE  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // frame status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // event kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // dle flag bits
    localparam int FL_SINGLE = 0;
    localparam int FL_DOUBLE = 1;
    localparam int FL_AFTER  = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd220;
    localparam int          QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] reply_code;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] frame_status;
    } out_item_t;

    // classified event handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       is_stx;
        logic       is_etx;
        logic       is_dle;
        logic [7:0] data;
    } cls_item_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DATA = 3'b010,
        PH_BCC  = 3'b100
    } phase_t;

endpackage

// ----- rtl/core/s3964_front.sv -----
// front stage: accepts input items and classifies them into events
// depends on s3964_pkg

module s3964_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  s3964_pkg::in_item_t in_item,
    output logic                push,
    output s3964_pkg::cls_item_t push_item,
    input  logic                q_full
);
    import s3964_pkg::*;

    logic      valid_reg, valid_next;
    cls_item_t cls_reg, cls_next;
    logic      take;

    assign push      = valid_reg && !q_full;
    assign in_stall  = valid_reg && q_full;
    assign take      = in_valid && !in_stall;
    assign push_item = cls_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cls_next   = cls_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next       = 1'b1;
            cls_next.is_tick = (in_item.mode == MODE_TICK);
            cls_next.is_stx  = (in_item.rx_byte == CH_STX);
            cls_next.is_etx  = (in_item.rx_byte == CH_ETX);
            cls_next.is_dle  = (in_item.rx_byte == CH_DLE);
            cls_next.data    = in_item.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

endmodule

// ----- rtl/core/s3964_queue.sv -----
// short fifo of classified events between front and back
// depends on s3964_pkg

module s3964_queue #(
    parameter int DEPTH = s3964_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  s3964_pkg::cls_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output s3964_pkg::cls_item_t pop_item,
    output logic                 empty
);
    import s3964_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cls_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/s3964_back.sv -----
// back stage: link protocol state, block check, destuffing and result register
// depends on s3964_pkg

module s3964_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          timeout_ticks,
    input  logic                 q_empty,
    input  s3964_pkg::cls_item_t q_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output s3964_pkg::out_item_t out_item
);
    import s3964_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] bcc_reg, bcc_next;
    logic       prev_dle_reg, prev_dle_next;
    logic [2:0] flags_reg, flags_next;
    logic [15:0] tick_reg, tick_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    out_item_t   res;
    logic [15:0] tick_inc;
    logic        go_idle;

    assign pop       = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign tick_inc  = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        bcc_next      = bcc_reg;
        prev_dle_next = prev_dle_reg;
        flags_next    = flags_reg;
        tick_next     = tick_reg;
        res           = '0;
        go_idle       = 1'b0;

        if (q_item.is_tick)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_ticks)
                begin
                    res.reply_code   = REPLY_NAK;
                    res.frame_status = ST_BAD;
                    go_idle          = 1'b1;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_item.is_stx)
                    begin
                        phase_next     = PH_DATA;
                        bcc_next       = CH_STX;
                        res.reply_code = REPLY_DLE;
                    end
                    else
                    begin
                        res.reply_code = REPLY_NAK;
                    end
                end
                PH_DATA:
                begin
                    tick_next     = '0;
                    bcc_next      = bcc_reg ^ q_item.data;
                    prev_dle_next = q_item.is_dle;
                    priority if (!prev_dle_reg && q_item.is_dle)
                    begin
                        flags_next = 3'b001 << FL_SINGLE;
                    end
                    else if (prev_dle_reg && q_item.is_dle)
                    begin
                        if (!flags_reg[FL_DOUBLE])
                        begin
                            // doubled dle gives one payload dle
                            flags_next        = 3'b001 << FL_DOUBLE;
                            res.payload_valid = 1'b1;
                            res.payload_byte  = CH_DLE;
                        end
                        else
                        begin
                            // third dle opens a new end mark
                            flags_next = 3'b001 << FL_SINGLE;
                        end
                    end
                    else if (prev_dle_reg)
                    begin
                        if (flags_reg[FL_SINGLE])
                        begin
                            if (q_item.is_etx)
                            begin
                                phase_next = PH_BCC;
                                flags_next = (3'b001 << FL_SINGLE) | (3'b001 << FL_AFTER);
                            end
                            else
                            begin
                                res.reply_code   = REPLY_NAK;
                                res.frame_status = ST_BAD;
                                go_idle          = 1'b1;
                            end
                        end
                        else
                        begin
                            flags_next        = 3'b001 << FL_AFTER;
                            res.payload_valid = 1'b1;
                            res.payload_byte  = q_item.data;
                        end
                    end
                    else
                    begin
                        flags_next        = '0;
                        res.payload_valid = 1'b1;
                        res.payload_byte  = q_item.data;
                    end
                end
                PH_BCC:
                begin
                    if (q_item.data == bcc_reg)
                    begin
                        res.reply_code   = REPLY_DLE;
                        res.frame_status = ST_GOOD;
                    end
                    else
                    begin
                        res.reply_code   = REPLY_NAK;
                        res.frame_status = ST_BAD;
                    end
                    go_idle = 1'b1;
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase
        end

        if (go_idle)
        begin
            phase_next    = PH_IDLE;
            bcc_next      = '0;
            prev_dle_next = 1'b0;
            flags_next    = '0;
            tick_next     = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bcc_reg       <= '0;
            prev_dle_reg  <= 1'b0;
            flags_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                bcc_reg      <= bcc_next;
                prev_dle_reg <= prev_dle_next;
                flags_reg    <= flags_next;
                tick_reg     <= tick_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ----- rtl/core/serial_3964r_receiver_core.sv -----
// top level of the 3964r link receiver core
// depends on s3964_pkg, s3964_front, s3964_queue, s3964_back

// Receiver side of a 3964R serial link. Each input item is either one
// received character (mode 0) or one timer tick (mode 1), and each item
// yields exactly one result item: the reply character to send (none, DLE
// or NAK), an optional destuffed payload byte and a frame status (none,
// accepted, rejected). An STX while idle opens a frame and is answered
// with DLE; doubled DLEs collapse to one payload DLE; DLE ETX followed by
// a matching XOR block check closes the frame with DLE and an accepted
// status. A wrong terminator, a wrong check or a character timeout gives
// NAK and a rejected status. The timeout register counts ticks allowed
// between characters of an open frame (reset 220) and is written through
// the cfg channel, which is always ready; write it only while no item is
// in flight. Throughput is one item per clock while nothing stalls: a front
// stage registers and classifies items, a short fifo decouples it from the
// back stage, and the back stage updates the link state and fills the
// output register for each item that it pops. An accepted item passes the
// front register, the fifo and the output register before its result is
// valid. Input stall rises only when the front stage holds an item and
// the fifo is full; output stall holds the result register and backs
// items up into the fifo.

module serial_3964r_receiver_core #(
    parameter int QUEUE_DEPTH = s3964_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  s3964_pkg::in_item_t  in_item,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output s3964_pkg::out_item_t out_item,
    // timeout register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import s3964_pkg::*;

    logic [15:0] timeout_ticks_reg, timeout_ticks_next;
    logic        push, q_full, q_empty, pop;
    cls_item_t   push_item, q_item;

    // register port never back-pressures
    assign cfg_ready = 1'b1;

    always_comb
    begin
        timeout_ticks_next = timeout_ticks_reg;
        if (cfg_valid && cfg_ready)
        begin
            timeout_ticks_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    // front: accept and classify
    s3964_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // decoupling fifo
    s3964_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // back: link state machine and result register
    s3964_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_ticks_reg),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

endmodule
